// ===== hdl/lrutlb_pkg.sv =====
// ----------------------------------------------------------------------------
// lrutlb_pkg
// Shared sizes, codes and payload types for the fully associative
// translation buffer with least-recently-used replacement.
// ----------------------------------------------------------------------------
package lrutlb_pkg;

   localparam int ENTRY_COUNT      = 64;
   localparam int PAGE_OFFSET_BITS = 12;
   localparam int ADDR_W           = 32;
   localparam int XLAT_W           = 32;
   localparam int PAGE_W           = ADDR_W - PAGE_OFFSET_BITS;
   localparam int INDEX_W          = $clog2(ENTRY_COUNT);
   localparam int COUNT_W          = $clog2(ENTRY_COUNT + 1);
   localparam int CSR_W            = 6;
   localparam int OCC_W            = 7;
   localparam int TOTAL_W          = 32;

   typedef logic [ENTRY_COUNT-1:0] entry_vec_type;
   typedef logic [INDEX_W-1:0]     index_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [PAGE_W-1:0]      page_type;
   typedef logic [CSR_W-1:0]       csr_type;

   localparam entry_vec_type FIRST_ENTRY = {{(ENTRY_COUNT-1){1'b0}}, 1'b1};
   localparam index_type     LAST_RANK   = index_type'(ENTRY_COUNT - 1);
   localparam count_type     FULL_COUNT  = count_type'(ENTRY_COUNT);
   localparam csr_type       ADDR_BITS_RESET = csr_type'(32);

   typedef enum logic [1:0] {
      OP_LOOKUP     = 2'd0,
      OP_INSERT     = 2'd1,
      OP_INVALIDATE = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      STATUS_HIT         = 3'd0,
      STATUS_MISS        = 3'd1,
      STATUS_BAD_ADDRESS = 3'd2,
      STATUS_INSERTED    = 3'd3,
      STATUS_EVICTED     = 3'd4,
      STATUS_INVALIDATED = 3'd5,
      STATUS_NOT_FOUND   = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] vaddr;
      logic [XLAT_W-1:0] translation_in;
   } req_payload_type;

   typedef struct packed {
      status_type         status;
      logic [XLAT_W-1:0]  translation_out;
      logic [OCC_W-1:0]   occupancy;
      logic [TOTAL_W-1:0] lookup_total;
      logic [TOTAL_W-1:0] miss_total;
   } rsp_payload_type;

   // update command into the entry array, already qualified by the pipeline
   typedef struct packed {
      logic     lookup;
      logic     insert;
      logic     invalidate;
      page_type page;
   } cmd_type;

   typedef struct packed {
      logic      hit;
      logic      full;
      index_type slot;
   } match_type;

endpackage

// ===== hdl/lrutlb_order.sv =====
// ----------------------------------------------------------------------------
// lrutlb_order
// Entry tags, valid bits and age ranks. Parallel page compare, victim and
// free-slot select, and the rank update for promote and remove.
// ----------------------------------------------------------------------------
module lrutlb_order (
   input  logic                  clock,
   input  logic                  reset,
   input  lrutlb_pkg::cmd_type   cmd,
   output lrutlb_pkg::match_type match,
   output lrutlb_pkg::count_type occupancy
);

   lrutlb_pkg::entry_vec_type valid_ff, valid_in;
   lrutlb_pkg::index_type     rank_ff [lrutlb_pkg::ENTRY_COUNT];
   lrutlb_pkg::index_type     rank_in [lrutlb_pkg::ENTRY_COUNT];
   lrutlb_pkg::page_type      page_ff [lrutlb_pkg::ENTRY_COUNT];
   lrutlb_pkg::count_type     count_ff, count_in;

   lrutlb_pkg::entry_vec_type hit_vec, oldest_vec, free_vec, sel_vec;
   lrutlb_pkg::index_type     sel_rank, ref_rank, slot;
   logic                      hit, full, new_slot, promote, demote;

   always_comb begin
      for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++) begin
         hit_vec[i]    = valid_ff[i] && (page_ff[i] == cmd.page);
         oldest_vec[i] = valid_ff[i] && (rank_ff[i] == lrutlb_pkg::LAST_RANK);
      end
      // lowest clear valid bit
      free_vec = ~valid_ff & (valid_ff + lrutlb_pkg::FIRST_ENTRY);
      hit      = |hit_vec;
      full     = (count_ff == lrutlb_pkg::FULL_COUNT);
      new_slot = cmd.insert && !hit && !full;

      priority if (hit) begin
         sel_vec = hit_vec;
      end else if (full) begin
         sel_vec = (|oldest_vec) ? oldest_vec : lrutlb_pkg::FIRST_ENTRY;
      end else begin
         sel_vec = free_vec;
      end

      slot     = '0;
      sel_rank = '0;
      for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++) begin
         slot     = slot | (sel_vec[i] ? lrutlb_pkg::index_type'(i) : '0);
         sel_rank = sel_rank | (sel_vec[i] ? rank_ff[i] : '0);
      end

      promote  = (cmd.lookup && hit) || cmd.insert;
      demote   = cmd.invalidate && hit;
      // a fresh slot enters at the tail, so every valid entry ages
      ref_rank = new_slot ? lrutlb_pkg::index_type'(count_ff) : sel_rank;
   end

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++) begin
         rank_in[i] = rank_ff[i];
         if (promote) begin
            if (sel_vec[i]) begin
               rank_in[i] = '0;
               if (new_slot) begin
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && (rank_ff[i] < ref_rank)) begin
               rank_in[i] = rank_ff[i] + lrutlb_pkg::index_type'(1);
            end
         end else if (demote) begin
            if (sel_vec[i]) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b0;
            end else if (valid_ff[i] && (rank_ff[i] > ref_rank)) begin
               rank_in[i] = rank_ff[i] - lrutlb_pkg::index_type'(1);
            end
         end
      end

      priority if (new_slot) begin
         count_in = count_ff + lrutlb_pkg::count_type'(1);
      end else if (demote) begin
         count_in = count_ff - lrutlb_pkg::count_type'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // tags are only read behind a valid bit
   always_ff @(posedge clock) begin
      for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++) begin
         if (cmd.insert && !hit && sel_vec[i]) begin
            page_ff[i] <= cmd.page;
         end
      end
   end

   assign match.hit  = hit;
   assign match.full = full;
   assign match.slot = slot;
   assign occupancy  = count_ff;

endmodule

// ===== hdl/lru_translation_lookaside_buffer.sv =====
// ----------------------------------------------------------------------------
// lru_translation_lookaside_buffer
// Fully associative translation buffer, least-recently-used replacement.
// ----------------------------------------------------------------------------
// Pipeline: the request register, then the result register with the registered
//   translation memory read; a stall on rsp_stall holds both.
// Throughput: one request per cycle when not stalled; compare, rank update together.
// Reset: clears valid bits, ranks, occupancy and counters, address_bits to 32.
//   No clearing pass; tags and translations are undefined until written.
module lru_translation_lookaside_buffer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lrutlb_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lrutlb_pkg::rsp_payload_type rsp_payload,
   input  logic                        csr_write_enable,
   input  lrutlb_pkg::csr_type         csr_write_data
);

   logic                          req_valid_ff, req_valid_in;
   lrutlb_pkg::req_payload_type   req_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   lrutlb_pkg::status_type        status_ff, status_in;
   logic [lrutlb_pkg::XLAT_W-1:0] xlat_rd_ff;
   logic [lrutlb_pkg::TOTAL_W-1:0] lookup_ff, lookup_in, miss_ff, miss_in;
   lrutlb_pkg::csr_type           addr_bits_ff;

   logic [lrutlb_pkg::XLAT_W-1:0] xlat_mem [lrutlb_pkg::ENTRY_COUNT];

   logic                  advance, fault, is_lookup, is_insert, is_inval;
   lrutlb_pkg::cmd_type   cmd;
   lrutlb_pkg::match_type match;
   lrutlb_pkg::count_type occupancy_w;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   assign is_lookup = (req_ff.opcode == lrutlb_pkg::OP_LOOKUP);
   assign is_insert = (req_ff.opcode == lrutlb_pkg::OP_INSERT);
   assign is_inval  = (req_ff.opcode == lrutlb_pkg::OP_INVALIDATE);
   // shift of 32 or more clears the word, so wide settings never fault
   assign fault     = ((req_ff.vaddr >> addr_bits_ff) != '0);

   assign cmd.lookup     = advance && is_lookup && !fault;
   assign cmd.insert     = advance && is_insert;
   assign cmd.invalidate = advance && is_inval;
   assign cmd.page       =
      req_ff.vaddr[lrutlb_pkg::ADDR_W-1:lrutlb_pkg::PAGE_OFFSET_BITS];

   lrutlb_order u_order (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .match     (match),
      .occupancy (occupancy_w)
   );

   always_comb begin
      unique case (req_ff.opcode)
         lrutlb_pkg::OP_LOOKUP: begin
            priority if (fault) begin
               status_in = lrutlb_pkg::STATUS_BAD_ADDRESS;
            end else if (match.hit) begin
               status_in = lrutlb_pkg::STATUS_HIT;
            end else begin
               status_in = lrutlb_pkg::STATUS_MISS;
            end
         end
         lrutlb_pkg::OP_INSERT: begin
            status_in = (!match.hit && match.full) ? lrutlb_pkg::STATUS_EVICTED
                                                   : lrutlb_pkg::STATUS_INSERTED;
         end
         lrutlb_pkg::OP_INVALIDATE: begin
            status_in = match.hit ? lrutlb_pkg::STATUS_INVALIDATED
                                  : lrutlb_pkg::STATUS_NOT_FOUND;
         end
         default: begin
            status_in = lrutlb_pkg::STATUS_NOT_FOUND;
         end
      endcase

      lookup_in = lookup_ff;
      miss_in   = miss_ff;
      if (cmd.lookup) begin
         lookup_in = lookup_ff + lrutlb_pkg::TOTAL_W'(1);
         if (!match.hit) begin
            miss_in = miss_ff + lrutlb_pkg::TOTAL_W'(1);
         end
      end

      req_valid_in = req_valid && !req_stall ? 1'b1 : (req_valid_ff && !advance);
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lookup_ff    <= '0;
         miss_ff      <= '0;
         addr_bits_ff <= lrutlb_pkg::ADDR_BITS_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         lookup_ff    <= lookup_in;
         miss_ff      <= miss_in;
         if (csr_write_enable) begin
            addr_bits_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         xlat_mem[match.slot] <= req_ff.translation_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xlat_rd_ff <= xlat_mem[match.slot];
      end
   end

   // counters and occupancy only move on advance, so they hold with the result
   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_payload.status          = status_ff;
   assign rsp_payload.translation_out =
      (status_ff == lrutlb_pkg::STATUS_HIT) ? xlat_rd_ff : '0;
   assign rsp_payload.occupancy       = lrutlb_pkg::OCC_W'(occupancy_w);
   assign rsp_payload.lookup_total    = lookup_ff;
   assign rsp_payload.miss_total      = miss_ff;

   a_miss_counts_lookup: assert property (@(posedge clock) disable iff (reset)
      (miss_ff != $past(miss_ff)) |-> (lookup_ff != $past(lookup_ff)))
      else $error("miss counted without a lookup");

   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == lrutlb_pkg::STATUS_EVICTED))
         |-> (occupancy_w == lrutlb_pkg::FULL_COUNT))
      else $error("eviction reported while not full");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall)
         |=> ($stable(lookup_ff) && $stable(miss_ff) && $stable(occupancy_w)))
      else $error("buffer state moved under a stalled result");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU translation buffer. A scoreboard keeps its
// own copy of tags, translations, LRU ranks and counters, predicts every
// response and compares it field by field. Stimulus is a short directed run,
// then random requests over a page pool sized above the entry count (so the
// buffer fills and evicts), across several address width settings.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int         POOL_SIZE   = 96;
   localparam int         SETTLE      = 8;

   class translation_scoreboard;
      lrutlb_pkg::page_type              tag[lrutlb_pkg::ENTRY_COUNT];
      logic [lrutlb_pkg::XLAT_W-1:0]     xlat[lrutlb_pkg::ENTRY_COUNT];
      bit                                present[lrutlb_pkg::ENTRY_COUNT];
      int unsigned                       age[lrutlb_pkg::ENTRY_COUNT];
      int unsigned                       resident;
      logic [31:0]                       lookups;
      logic [31:0]                       misses;
      int unsigned                       addr_bits;
      lrutlb_pkg::rsp_payload_type       expected_responses[$];
      int unsigned       errors, checked, hits, miss_seen, faults, evictions;

      function new();
         resident  = 0;
         lookups   = '0;
         misses    = '0;
         addr_bits = 32;
         errors    = 0;
         checked   = 0;
         hits      = 0;
         miss_seen = 0;
         faults    = 0;
         evictions = 0;
         foreach (present[i]) begin
            present[i] = 1'b0;
            age[i]     = 0;
         end
      endfunction

      function void set_address_bits(lrutlb_pkg::csr_type v);
         addr_bits = v;
      endfunction

      function int find_slot(lrutlb_pkg::page_type pg);
         for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++)
            if (present[i] && tag[i] == pg)
               return i;
         return -1;
      endfunction

      // entries younger than r age by one, slot s becomes most recent
      function void promote(int s, int unsigned r);
         for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++)
            if (present[i] && i != s && age[i] < r)
               age[i]++;
         age[s] = 0;
      endfunction

      function lrutlb_pkg::rsp_payload_type translate(lrutlb_pkg::req_payload_type p);
         lrutlb_pkg::rsp_payload_type res;
         lrutlb_pkg::page_type        pg;
         int                          s;
         int unsigned                 r;
         pg = lrutlb_pkg::page_type'(p.vaddr >> lrutlb_pkg::PAGE_OFFSET_BITS);
         res.status          = lrutlb_pkg::STATUS_NOT_FOUND;
         res.translation_out = '0;
         case (p.opcode)
            lrutlb_pkg::OP_LOOKUP: begin
               if (addr_bits < 32 && (p.vaddr >> addr_bits) != 0) begin
                  res.status = lrutlb_pkg::STATUS_BAD_ADDRESS;
               end else begin
                  lookups++;
                  s = find_slot(pg);
                  if (s >= 0) begin
                     res.status          = lrutlb_pkg::STATUS_HIT;
                     res.translation_out = xlat[s];
                     promote(s, age[s]);
                  end else begin
                     res.status = lrutlb_pkg::STATUS_MISS;
                     misses++;
                  end
               end
            end
            lrutlb_pkg::OP_INSERT: begin
               s = find_slot(pg);
               if (s >= 0) begin
                  // repair of a resident page
                  res.status = lrutlb_pkg::STATUS_INSERTED;
                  xlat[s]    = p.translation_in;
                  promote(s, age[s]);
               end else begin
                  if (resident >= lrutlb_pkg::ENTRY_COUNT) begin
                     res.status = lrutlb_pkg::STATUS_EVICTED;
                     for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++)
                        if (present[i] && age[i] == lrutlb_pkg::ENTRY_COUNT - 1)
                           s = i;
                     if (s < 0)
                        s = 0;
                  end else begin
                     res.status = lrutlb_pkg::STATUS_INSERTED;
                     for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++)
                        if (!present[i]) begin
                           s = i;
                           break;
                        end
                     present[s] = 1'b1;
                     age[s]     = resident;
                     resident++;
                  end
                  tag[s]  = pg;
                  xlat[s] = p.translation_in;
                  promote(s, age[s]);
               end
            end
            lrutlb_pkg::OP_INVALIDATE: begin
               s = find_slot(pg);
               if (s >= 0) begin
                  r          = age[s];
                  res.status = lrutlb_pkg::STATUS_INVALIDATED;
                  present[s] = 1'b0;
                  age[s]     = 0;
                  for (int i = 0; i < lrutlb_pkg::ENTRY_COUNT; i++)
                     if (present[i] && age[i] > r)
                        age[i]--;
                  resident--;
               end
            end
            default: ;
         endcase
         res.occupancy    = lrutlb_pkg::OCC_W'(resident);
         res.lookup_total = lookups;
         res.miss_total   = misses;
         return res;
      endfunction

      function void note_request(lrutlb_pkg::req_payload_type p);
         expected_responses.push_back(translate(p));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_response(lrutlb_pkg::rsp_payload_type got);
         lrutlb_pkg::rsp_payload_type want;
         if (expected_responses.size() == 0) begin
            errors++;
            $display("%0t: response with none pending, expected none actual %h",
                     $time, got);
            return;
         end
         want = expected_responses.pop_front();
         checked++;
         case (want.status)
            lrutlb_pkg::STATUS_HIT:         hits++;
            lrutlb_pkg::STATUS_MISS:        miss_seen++;
            lrutlb_pkg::STATUS_BAD_ADDRESS: faults++;
            lrutlb_pkg::STATUS_EVICTED:     evictions++;
            default: ;
         endcase
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("translation_out", want.translation_out, got.translation_out);
         compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
         compare_field("lookup_total", want.lookup_total, got.lookup_total);
         compare_field("miss_total", want.miss_total, got.miss_total);
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction
   endclass

   typedef struct {
      lrutlb_pkg::csr_type addr_bits;
      int                  ins_pct;
      int                  inv_pct;
      int                  count;
   } phase_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   lrutlb_pkg::req_payload_type req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   lrutlb_pkg::rsp_payload_type rsp_payload;
   logic                        csr_write_enable = 1'b0;
   lrutlb_pkg::csr_type         csr_write_data = lrutlb_pkg::ADDR_BITS_RESET;

   translation_scoreboard sb = new();
   lrutlb_pkg::page_type  page_pool[POOL_SIZE];
   int unsigned           burst_left = 0;
   int unsigned           stall_left = 0;
   int unsigned           stall_mode = 0;

   // phases sweep the address width, the last ones drain and refill the buffer
   phase_type phases[7] = '{
      '{lrutlb_pkg::csr_type'(32), 40, 10, 300},
      '{lrutlb_pkg::csr_type'(13), 30, 10, 250},
      '{lrutlb_pkg::csr_type'(63), 35, 10, 250},
      '{lrutlb_pkg::csr_type'(0),  25, 15, 200},
      '{lrutlb_pkg::csr_type'(20), 20, 40, 300},
      '{lrutlb_pkg::csr_type'(12), 35, 10, 250},
      '{lrutlb_pkg::csr_type'(32), 35,  5, 350}
   };

   lru_translation_lookaside_buffer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // receiver stall pattern: free-flowing, light and heavy stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(2);
            stall_left = $urandom_range(10, 80);
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(3) == 0);
            default: rsp_stall <= ($urandom_range(3) != 0);
         endcase
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_payload);

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic lrutlb_pkg::req_payload_type make_request(logic [1:0] op,
                                                                logic [31:0] va,
                                                                logic [31:0] tin);
      lrutlb_pkg::req_payload_type p;
      p.opcode         = op;
      p.vaddr          = va;
      p.translation_in = tin;
      return p;
   endfunction

   function automatic lrutlb_pkg::req_payload_type random_request(int ins_pct,
                                                                  int inv_pct);
      int          roll;
      logic [1:0]  op;
      logic [31:0] va;
      roll = $urandom_range(99);
      if (roll < ins_pct)
         op = lrutlb_pkg::OP_INSERT;
      else if (roll < ins_pct + inv_pct)
         op = lrutlb_pkg::OP_INVALIDATE;
      else if (roll < ins_pct + inv_pct + 4)
         op = OP_RESERVED;
      else
         op = lrutlb_pkg::OP_LOOKUP;
      if ($urandom_range(9) == 0)
         va = $urandom();
      else
         va = {page_pool[$urandom_range(POOL_SIZE - 1)], 12'($urandom())};
      return make_request(op, va, $urandom());
   endfunction

   task automatic drive_request(lrutlb_pkg::req_payload_type p);
      if (burst_left == 0) begin
         int unsigned gap;
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      sb.note_request(p);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_address_bits(lrutlb_pkg::csr_type v);
      drain();
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      sb.set_address_bits(v);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      lrutlb_pkg::req_payload_type directed[$];
      int unsigned                 total;
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < 8)
            page_pool[i] = lrutlb_pkg::page_type'(i);
         else if (i < 24)
            page_pool[i] = lrutlb_pkg::page_type'($urandom_range(255));
         else
            page_pool[i] = lrutlb_pkg::page_type'($urandom());
      end

      directed.push_back(make_request(lrutlb_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0));
      directed.push_back(make_request(lrutlb_pkg::OP_INVALIDATE, 32'h0000_0000, 32'h0));
      directed.push_back(make_request(OP_RESERVED, 32'h0000_0000, 32'h0));
      directed.push_back(make_request(lrutlb_pkg::OP_INSERT, 32'h0000_0000,
                                      32'hFFFF_FFFF));
      directed.push_back(make_request(lrutlb_pkg::OP_INSERT, 32'hFFFF_FFFF,
                                      32'h0000_0000));
      directed.push_back(make_request(lrutlb_pkg::OP_LOOKUP, 32'h0000_0FFF, 32'h0));
      directed.push_back(make_request(lrutlb_pkg::OP_LOOKUP, 32'hFFFF_F000,
                                      32'hFFFF_FFFF));
      // repair: same page, new translation
      directed.push_back(make_request(lrutlb_pkg::OP_INSERT, 32'h0000_0ABC,
                                      32'hA5A5_A5A5));
      directed.push_back(make_request(lrutlb_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0));
      directed.push_back(make_request(lrutlb_pkg::OP_INVALIDATE, 32'hFFFF_FFFF, 32'h0));
      directed.push_back(make_request(lrutlb_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0));
      directed.push_back(make_request(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      directed.push_back(make_request(lrutlb_pkg::OP_INSERT, 32'h8000_0000,
                                      32'h5A5A_5A5A));
      directed.push_back(make_request(lrutlb_pkg::OP_INVALIDATE, 32'h0000_0001, 32'h0));
      directed.push_back(make_request(lrutlb_pkg::OP_LOOKUP, 32'h8000_0FFF, 32'h0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         drive_request(directed[i]);
      total = directed.size();

      foreach (phases[k]) begin
         write_address_bits(phases[k].addr_bits);
         for (int n = 0; n < phases[k].count; n++)
            drive_request(random_request(phases[k].ins_pct, phases[k].inv_pct));
         total += phases[k].count;
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d requests over %0d address width settings; checked %0d responses",
               total, $size(phases) + 1, sb.checked);
      $display("  %0d hits, %0d misses, %0d bad addresses, %0d evictions, %0d errors",
               sb.hits, sb.miss_seen, sb.faults, sb.evictions, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/lrutlb_pkg.sv
hdl/lrutlb_order.sv
hdl/lru_translation_lookaside_buffer.sv
dv/testbench.sv
